// File: sv/spr_pkg.sv
// Shared types, widths, codes and the sine-squared threshold table.
package spr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;       // signed coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;           // signed product of two differences
  localparam int SUM_W      = PROD_W + 1;           // signed cross / dot sums
  localparam int NORM_W     = 2 * COORD_BITS + 1;   // squared lengths and magnitudes
  localparam int Q          = 30;                   // fraction bits of the sine table
  localparam int SIN_W      = 30;
  localparam int WIDE_W     = 2 * NORM_W + SIN_W;   // scaled products for angle tests
  localparam int ATOL_W     = 6;
  localparam int LTOL_W     = 12;
  localparam int T2_W       = 2 * LTOL_W;
  localparam int LCMP_W     = 2 * NORM_W + 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int SIN_TERMS  = 7;
  localparam int SIN_DEPTH  = 2 ** ATOL_W;
  localparam logic [63:0] DEG_Q30 = 64'd18740330;

  localparam logic [ATOL_W-1:0] ANGLE_TOL_RESET = ATOL_W'(5);
  localparam logic [LTOL_W-1:0] LEN_TOL_RESET   = LTOL_W'(5);

  // register index, taken from paddr[2]
  localparam logic REG_ANGLE_TOL = 1'b0;
  localparam logic REG_LEN_TOL   = 1'b1;

  typedef enum logic [2:0] {
    REL_PARALLEL = 3'd0,
    REL_RIGHT    = 3'd1,
    REL_ACUTE    = 3'd2,
    REL_OBTUSE   = 3'd3,
    REL_NO_MEET  = 3'd4
  } rel_t;

  typedef struct packed {
    rel_t relation;
    logic lengths_equal;
  } result_t;

  typedef struct packed {
    logic zero_len;
    logic meet;
    logic side_zero;
    logic side_neg;
    logic dot_zero;
    logic dot_neg;
  } geo_flags_t;

  typedef logic [SIN_W-1:0] sin2_tab_t [SIN_DEPTH];

  // sin^2 of each whole degree in Q30, Taylor series up to x^15
  function automatic sin2_tab_t sin2_table();
    sin2_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    longint      sum;
    int          d;
    int          k;
    for (d = 0; d < SIN_DEPTH; d++) begin
      x    = 64'(d) * DEG_Q30;
      x2   = (x * x) >> Q;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= SIN_TERMS; k++) begin
        term = ((term * x2) >> Q) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      s      = (sum < 0) ? 64'd0 : 64'(sum);
      tab[d] = SIN_W'((s * s) >> Q);
    end
    return tab;
  endfunction

endpackage

// File: sv/spr_pair_if.sv
// Handshake channel carrying one segment pair.
interface spr_pair_if;
  logic                           valid;
  logic                           ready;
  logic [spr_pkg::COORD_BITS-1:0] a_start_x;
  logic [spr_pkg::COORD_BITS-1:0] a_start_y;
  logic [spr_pkg::COORD_BITS-1:0] a_end_x;
  logic [spr_pkg::COORD_BITS-1:0] a_end_y;
  logic [spr_pkg::COORD_BITS-1:0] b_start_x;
  logic [spr_pkg::COORD_BITS-1:0] b_start_y;
  logic [spr_pkg::COORD_BITS-1:0] b_end_x;
  logic [spr_pkg::COORD_BITS-1:0] b_end_y;

  modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

// File: sv/spr_result_if.sv
// Handshake channel carrying one classification result.
interface spr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] relation;
  logic       lengths_equal;

  modport source (output valid, relation, lengths_equal, input ready);
  modport sink (input valid, relation, lengths_equal, output ready);
endinterface

// File: sv/spr_skid.sv
// Output register with a spare entry so the pipeline stalls only on a registered flag.
module spr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  spr_pkg::result_t data,
  output logic             ready,
  spr_result_if.source     result
);

  logic             out_valid;
  spr_pkg::result_t out_data;
  logic             spare_valid;
  spr_pkg::result_t spare;
  logic             take;

  assign take  = out_valid & result.ready;
  assign ready = ~spare_valid;

  assign result.valid         = out_valid;
  assign result.relation      = out_data.relation;
  assign result.lengths_equal = out_data.lengths_equal;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (take) begin
        out_data    <= spare;
        spare_valid <= 1'b0;
      end
    end else if (load) begin
      if (!out_valid || take) begin
        out_data  <= data;
        out_valid <= 1'b1;
      end else begin
        // hold the beat aside while the output waits
        spare       <= data;
        spare_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/segment_pair_relation_classifier_core.sv
// Top level: segment pair relation pipeline with APB register port.
//
//  channel  | kind        | direction | contents
//  ---------+-------------+-----------+-----------------------------------
//  pair     | valid/ready | in        | endpoints of segments A and B
//  result   | valid/ready | out       | relation, lengths_equal
//  APB      | psel/penable| in/out    | right_angle_tolerance, length_tolerance
//
// Seven register stages, then an output register with one spare entry.
// One pair enters per cycle while the spare entry is empty; results leave in order.
// The stage depth is set by the 25x30 threshold multipliers and the 80-bit compares.
// Reset clears the valid bits and loads both tolerances with 5.
// A stalled output fills the spare entry; the pipeline then holds as a whole.
module segment_pair_relation_classifier_core (
  input  logic                         clk,
  input  logic                         rst,
  spr_pair_if.sink                     pair,
  spr_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spr_pkg::ADDR_W-1:0]   paddr,
  input  logic [spr_pkg::DATA_W-1:0]   pwdata,
  output logic [spr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int DW = spr_pkg::DIFF_W;
  localparam int PW = spr_pkg::PROD_W;
  localparam int SW = spr_pkg::SUM_W;
  localparam int NW = spr_pkg::NORM_W;
  localparam int XW = spr_pkg::WIDE_W;
  localparam int PPW = NW + spr_pkg::SIN_W;
  localparam spr_pkg::sin2_tab_t SIN2_TAB = spr_pkg::sin2_table();
  localparam logic [spr_pkg::SIN_W-1:0] SIN2_ONE = SIN2_TAB[1];

  // configuration
  logic [spr_pkg::ATOL_W-1:0] angle_tol;
  logic [spr_pkg::LTOL_W-1:0] len_tol;
  logic [spr_pkg::SIN_W-1:0]  sin2_tol;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_tol <= spr_pkg::ANGLE_TOL_RESET;
      len_tol   <= spr_pkg::LEN_TOL_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == spr_pkg::REG_ANGLE_TOL) begin
        angle_tol <= pwdata[spr_pkg::ATOL_W-1:0];
      end else begin
        len_tol <= pwdata[spr_pkg::LTOL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sin2_tol <= SIN2_TAB[angle_tol];
  end

  always_comb begin
    if (paddr[2] == spr_pkg::REG_LEN_TOL) begin
      prdata = spr_pkg::DATA_W'(len_tol);
    end else begin
      prdata = spr_pkg::DATA_W'(angle_tol);
    end
  end

  // pipeline control
  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7;

  assign pair.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5, v6, v7} <= {pair.valid, v1, v2, v3, v4, v5, v6};
    end
  end

  // stage 1: direction vectors and offset
  logic signed [DW-1:0] s1_rx, s1_ry, s1_sx, s1_sy, s1_wx, s1_wy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx <= $signed({1'b0, pair.a_end_x}) - $signed({1'b0, pair.a_start_x});
      s1_ry <= $signed({1'b0, pair.a_end_y}) - $signed({1'b0, pair.a_start_y});
      s1_sx <= $signed({1'b0, pair.b_end_x}) - $signed({1'b0, pair.b_start_x});
      s1_sy <= $signed({1'b0, pair.b_end_y}) - $signed({1'b0, pair.b_start_y});
      s1_wx <= $signed({1'b0, pair.b_start_x}) - $signed({1'b0, pair.a_start_x});
      s1_wy <= $signed({1'b0, pair.b_start_y}) - $signed({1'b0, pair.a_start_y});
    end
  end

  // stage 2: pairwise products
  logic signed [PW-1:0] s2_rxsy, s2_rysx, s2_wxsy, s2_wysx, s2_wxry, s2_wyrx;
  logic signed [PW-1:0] s2_rxsx, s2_rysy, s2_rxrx, s2_ryry, s2_sxsx, s2_sysy;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rxsy <= s1_rx * s1_sy;
      s2_rysx <= s1_ry * s1_sx;
      s2_wxsy <= s1_wx * s1_sy;
      s2_wysx <= s1_wy * s1_sx;
      s2_wxry <= s1_wx * s1_ry;
      s2_wyrx <= s1_wy * s1_rx;
      s2_rxsx <= s1_rx * s1_sx;
      s2_rysy <= s1_ry * s1_sy;
      s2_rxrx <= s1_rx * s1_rx;
      s2_ryry <= s1_ry * s1_ry;
      s2_sxsx <= s1_sx * s1_sx;
      s2_sysy <= s1_sy * s1_sy;
    end
  end

  // stage 3: cross products, dot product, squared lengths
  logic signed [SW-1:0] s3_d, s3_tn, s3_un, s3_dot;
  logic [NW-1:0]        s3_n1, s3_n2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_d   <= SW'(s2_rxsy) - SW'(s2_rysx);
      s3_tn  <= SW'(s2_wxsy) - SW'(s2_wysx);
      s3_un  <= SW'(s2_wxry) - SW'(s2_wyrx);
      s3_dot <= SW'(s2_rxsx) + SW'(s2_rysy);
      s3_n1  <= NW'(SW'(s2_rxrx) + SW'(s2_ryry));
      s3_n2  <= NW'(SW'(s2_sxsx) + SW'(s2_sysy));
    end
  end

  // stage 4: fold the sign of d, range and side tests, length ordering
  logic signed [SW-1:0] dm, tnm, unm;
  logic signed [SW:0]   side_a, side_b;
  logic                 n1_big;
  logic [NW-1:0]        big_n, small_n;

  always_comb begin
    dm      = s3_d[SW-1] ? -s3_d : s3_d;
    tnm     = s3_d[SW-1] ? -s3_tn : s3_tn;
    unm     = s3_d[SW-1] ? -s3_un : s3_un;
    side_a  = (SW+1)'(dm) - ((SW+1)'(tnm) <<< 1);
    side_b  = (SW+1)'(dm) - ((SW+1)'(unm) <<< 1);
    n1_big  = s3_n1 > s3_n2;
    big_n   = n1_big ? s3_n1 : s3_n2;
    small_n = n1_big ? s3_n2 : s3_n1;
  end

  spr_pkg::geo_flags_t            s4_flags;
  logic [NW-1:0]                  s4_cd, s4_cdot, s4_n1, s4_n2, s4_diff, s4_small;
  logic [spr_pkg::T2_W-1:0]       s4_t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_flags.zero_len  <= (s3_n1 == '0) || (s3_n2 == '0);
      s4_flags.meet      <= !tnm[SW-1] && (tnm <= dm) && !unm[SW-1] && (unm <= dm);
      s4_flags.side_zero <= (side_a == '0) || (side_b == '0);
      s4_flags.side_neg  <= side_a[SW] ^ side_b[SW];
      s4_flags.dot_zero  <= s3_dot == '0;
      s4_flags.dot_neg   <= s3_dot[SW-1];
      s4_cd    <= NW'(dm);
      s4_cdot  <= NW'(s3_dot[SW-1] ? -s3_dot : s3_dot);
      s4_n1    <= s3_n1;
      s4_n2    <= s3_n2;
      s4_diff  <= big_n - small_n;
      s4_small <= small_n;
      s4_t2    <= len_tol * len_tol;
    end
  end

  // stage 5: squares and the length product
  spr_pkg::geo_flags_t      s5_flags;
  logic [2*NW-1:0]          s5_cd2, s5_cdot2, s5_lens;
  logic                     s5_lt2;
  logic [NW-1:0]            s5_rest, s5_small;
  logic [spr_pkg::T2_W-1:0] s5_t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_flags <= s4_flags;
      s5_cd2   <= s4_cd * s4_cd;
      s5_cdot2 <= s4_cdot * s4_cdot;
      s5_lens  <= s4_n1 * s4_n2;
      s5_lt2   <= s4_diff < NW'(s4_t2);
      s5_rest  <= s4_diff - NW'(s4_t2);
      s5_small <= s4_small;
      s5_t2    <= s4_t2;
    end
  end

  // stage 6: split threshold products, length test products
  spr_pkg::geo_flags_t       s6_flags;
  logic [2*NW-1:0]           s6_cd2, s6_cdot2, s6_rest2;
  logic [PPW-1:0]            s6_p1_lo, s6_p1_hi, s6_pt_lo, s6_pt_hi;
  logic                      s6_lt2;
  logic [spr_pkg::T2_W+NW-1:0] s6_tsm;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_flags <= s5_flags;
      s6_cd2   <= s5_cd2;
      s6_cdot2 <= s5_cdot2;
      s6_p1_lo <= s5_lens[NW-1:0] * SIN2_ONE;
      s6_p1_hi <= s5_lens[2*NW-1:NW] * SIN2_ONE;
      s6_pt_lo <= s5_lens[NW-1:0] * sin2_tol;
      s6_pt_hi <= s5_lens[2*NW-1:NW] * sin2_tol;
      s6_rest2 <= s5_rest * s5_rest;
      s6_tsm   <= s5_t2 * s5_small;
      s6_lt2   <= s5_lt2;
    end
  end

  // stage 7: wide compares
  logic [XW-1:0] rhs_par, rhs_tol, lhs_cross, lhs_dot;

  always_comb begin
    rhs_par   = (XW'(s6_p1_hi) << NW) + XW'(s6_p1_lo);
    rhs_tol   = (XW'(s6_pt_hi) << NW) + XW'(s6_pt_lo);
    lhs_cross = XW'(s6_cd2) << spr_pkg::Q;
    lhs_dot   = XW'(s6_cdot2) << spr_pkg::Q;
  end

  spr_pkg::geo_flags_t s7_flags;
  logic                s7_par, s7_right, s7_leq;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_flags <= s6_flags;
      s7_par   <= !(rhs_par < lhs_cross);
      s7_right <= s6_flags.dot_zero || (lhs_dot < rhs_tol);
      s7_leq   <= (len_tol != '0) &&
                  (s6_lt2 || (spr_pkg::LCMP_W'(s6_rest2) < (spr_pkg::LCMP_W'(s6_tsm) << 2)));
    end
  end

  // final decision into the output register
  spr_pkg::result_t res;

  always_comb begin
    res.lengths_equal = s7_leq;
    if (s7_flags.zero_len) begin
      res.relation = spr_pkg::REL_NO_MEET;
    end else if (s7_par) begin
      res.relation = spr_pkg::REL_PARALLEL;
    end else if (!s7_flags.meet || s7_flags.side_zero) begin
      res.relation = spr_pkg::REL_NO_MEET;
    end else if (s7_right) begin
      res.relation = spr_pkg::REL_RIGHT;
    end else if (s7_flags.side_neg ^ s7_flags.dot_neg) begin
      res.relation = spr_pkg::REL_OBTUSE;
    end else begin
      res.relation = spr_pkg::REL_ACUTE;
    end
  end

  spr_skid u_skid (
    .clk    (clk),
    .rst    (rst),
    .load   (v7 && adv),
    .data   (res),
    .ready  (adv),
    .result (result)
  );

endmodule
